[hdl/plfsr_pkg.sv]
// ----------------------------------------------------------------------------
// plfsr_pkg
// Shared widths, register indexes, reset values and control types of the
// parallel LFSR scrambler.
// ----------------------------------------------------------------------------
package plfsr_pkg;

  // Default build widths
  localparam int STATE_WIDTH_DEF = 31;
  localparam int WORD_WIDTH_DEF  = 64;

  // Fixed field widths on the ports
  localparam int DATA_FIELD_W  = 64;
  localparam int STATE_FIELD_W = 31;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int TAP_W      = 31;
  localparam int SEED_W     = 31;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_MASK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIBONACCI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_FORWARD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_BITS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED          = 3'd4;

  localparam logic [TAP_W-1:0]  TAP_RST  = 31'h1000_0001;
  localparam logic [SEED_W-1:0] SEED_RST = 31'h7fff_ffff;

  // Control from the register bank to the transfer-matrix builder
  typedef struct packed {
    logic fibonacci;     // 1: Fibonacci form, 0: Galois form
    logic feed_forward;  // 1: data bit enters the state
    logic rebuild;       // pulse: polynomial or form written
  } build_ctl_t;

endpackage

[hdl/plfsr_if.sv]
// ----------------------------------------------------------------------------
// plfsr_if
// Valid/ready channels of the parallel LFSR scrambler: input words and
// result words.
// ----------------------------------------------------------------------------
interface plfsr_in_if;
  logic                                valid;
  logic                                ready;
  logic [plfsr_pkg::DATA_FIELD_W-1:0]  data_in;
  logic                                restart;

  modport source (output valid, output data_in, output restart, input ready);
  modport sink   (input valid, input data_in, input restart, output ready);
endinterface

interface plfsr_out_if;
  logic                                valid;
  logic                                ready;
  logic [plfsr_pkg::DATA_FIELD_W-1:0]  data_out;
  logic [plfsr_pkg::STATE_FIELD_W-1:0] state_out;

  modport source (output valid, output data_out, output state_out, input ready);
  modport sink   (input valid, input data_out, input state_out, output ready);
endinterface

[hdl/parallel_lfsr_scrambler.sv]
// ----------------------------------------------------------------------------
// parallel_lfsr_scrambler
// Word-parallel LFSR scrambler / self-synchronising descrambler with
// programmable taps, Galois or Fibonacci form, feed-forward and bit reversal.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Transaction payload              Handshake
//  --------  ---  -------------------------------  ----------------
//  in_ch     in   data_in[63:0], restart           valid / ready
//  out_ch    out  data_out[63:0], state_out[30:0]  valid / ready
//  cfg       in   cfg_index[2:0], cfg_wdata[30:0]  cfg_we, no wait
//
//  One word per clock unless the result stalls or the matrix rebuilds: input
//  register, then one AND-XOR pass through the transfer matrix into the result
//  register. The next state is registered together with the result, so words run
//  back to back. Reset, and any write to tap_mask, fibonacci_mode or
//  feed_forward, rebuild the matrix one data bit per cycle, ready low.
//  A stalled result holds; the input stage takes one more word, then stalls.
//
module parallel_lfsr_scrambler #(
  parameter int STATE_WIDTH = plfsr_pkg::STATE_WIDTH_DEF,
  parameter int WORD_WIDTH  = plfsr_pkg::WORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  plfsr_in_if.sink                          in_ch,
  plfsr_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [plfsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plfsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SW = STATE_WIDTH;
  localparam int DW = WORD_WIDTH;
  localparam int NL = SW + DW;

  // Configuration registers
  logic [plfsr_pkg::TAP_W-1:0]  tap_mask;
  logic                         fibonacci_mode;
  logic                         feed_forward;
  logic                         reverse_bits;
  logic [plfsr_pkg::SEED_W-1:0] seed;

  // Transfer matrix
  plfsr_pkg::build_ctl_t        ctl;
  logic [SW-1:0]                taps;
  logic [SW-1:0]                col_state [NL];
  logic [DW-1:0]                col_data  [NL];
  logic                         matrix_ready;

  // Input stage, LFSR state, result stage
  logic                         in_vld;
  logic [DW-1:0]                in_data;
  logic                         in_restart;
  logic [SW-1:0]                lfsr_state;
  logic                         out_vld;

  logic                         advance;
  logic [SW-1:0]                s_src;
  logic [SW-1:0]                s_in;
  logic [DW-1:0]                d_in;
  logic [NL-1:0]                vec;
  logic [SW-1:0]                acc_s;
  logic [DW-1:0]                acc_r;
  logic [SW-1:0]                state_next;
  logic [DW-1:0]                res;

  function automatic logic [SW-1:0] rev_state(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    for (int i = 0; i < SW; i++) begin
      r[i] = v[SW-1-i];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] rev_data(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    for (int i = 0; i < DW; i++) begin
      r[i] = v[DW-1-i];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Register bank: drop writes to unknown indexes, keep only each
  // register's width.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_mask       <= plfsr_pkg::TAP_RST;
      fibonacci_mode <= 1'b0;
      feed_forward   <= 1'b0;
      reverse_bits   <= 1'b0;
      seed           <= plfsr_pkg::SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plfsr_pkg::REG_TAP_MASK:     tap_mask       <= cfg_wdata;
        plfsr_pkg::REG_FIBONACCI:    fibonacci_mode <= cfg_wdata[0];
        plfsr_pkg::REG_FEED_FORWARD: feed_forward   <= cfg_wdata[0];
        plfsr_pkg::REG_REVERSE_BITS: reverse_bits   <= cfg_wdata[0];
        plfsr_pkg::REG_SEED:         seed           <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Rebuild the matrix whenever the polynomial or the form is written; seed and
  // reversal act on the datapath only.
  assign ctl.fibonacci    = fibonacci_mode;
  assign ctl.feed_forward = feed_forward;
  assign ctl.rebuild      = cfg_we && ((cfg_index == plfsr_pkg::REG_TAP_MASK) ||
                                       (cfg_index == plfsr_pkg::REG_FIBONACCI) ||
                                       (cfg_index == plfsr_pkg::REG_FEED_FORWARD));

  // Bit 0 and taps beyond the state are ignored.
  assign taps = SW'(tap_mask) & ~SW'(1);

  plfsr_matrix #(
    .STATE_WIDTH (STATE_WIDTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .taps      (taps),
    .col_state (col_state),
    .col_data  (col_data),
    .ready     (matrix_ready)
  );

  // --------------------------------------------------------------------------
  // Handshake: advance the input stage whenever the result register is free
  // or being emptied; accept a new word whenever the input stage is free or
  // advancing, and the matrix is built.
  // --------------------------------------------------------------------------
  assign advance     = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = matrix_ready && (!in_vld || advance);
  assign out_ch.valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data    <= DW'(in_ch.data_in);
      in_restart <= in_ch.restart;
    end
  end

  // --------------------------------------------------------------------------
  // One pass: optional seed load, optional reversal, matrix product over
  // state and data bits, reversal back.
  // --------------------------------------------------------------------------
  assign s_src = in_restart ? SW'(seed) : lfsr_state;
  assign s_in  = reverse_bits ? rev_state(s_src) : s_src;
  assign d_in  = reverse_bits ? rev_data(in_data) : in_data;
  assign vec   = {d_in, s_in};

  always_comb begin
    acc_s = '0;
    acc_r = '0;
    for (int i = 0; i < NL; i++) begin
      if (vec[i]) begin
        acc_s = acc_s ^ col_state[i];
        acc_r = acc_r ^ col_data[i];
      end
    end
  end

  assign state_next = reverse_bits ? rev_state(acc_s) : acc_s;
  assign res        = reverse_bits ? rev_data(acc_r) : acc_r;

  // Hold the state until a word moves on; reset loads the seed reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_state <= SW'(plfsr_pkg::SEED_RST);
    end else if (advance) begin
      lfsr_state <= state_next;
    end
  end

  // Result register: hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.data_out  <= plfsr_pkg::DATA_FIELD_W'(res);
      out_ch.state_out <= plfsr_pkg::STATE_FIELD_W'(state_next);
    end
  end

endmodule

[hdl/plfsr_matrix.sv]
// ----------------------------------------------------------------------------
// plfsr_matrix
// Builds the GF(2) transfer matrix of one data word: one lane per input bit
// (state bits, then data bits) runs the bit-serial LFSR on its unit vector,
// one data bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module plfsr_matrix #(
  parameter int STATE_WIDTH = plfsr_pkg::STATE_WIDTH_DEF,
  parameter int WORD_WIDTH  = plfsr_pkg::WORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  plfsr_pkg::build_ctl_t       ctl,
  input  logic [STATE_WIDTH-1:0]      taps,
  output logic [STATE_WIDTH-1:0]      col_state [STATE_WIDTH+WORD_WIDTH],
  output logic [WORD_WIDTH-1:0]       col_data  [STATE_WIDTH+WORD_WIDTH],
  output logic                        ready
);

  localparam int SW = STATE_WIDTH;
  localparam int DW = WORD_WIDTH;
  localparam int NL = SW + DW;
  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DONE} build_state_t;

  build_state_t    state;
  logic [CW-1:0]   cnt;
  logic            load;
  logic            step;

  assign load = (state == ST_LOAD);
  assign step = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
      ready <= 1'b0;
    end else if (ctl.rebuild) begin
      state <= ST_LOAD;
      ready <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          cnt   <= CW'(DW - 1);
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (cnt == '0) begin
            state <= ST_DONE;
            ready <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_DONE: begin
          ready <= 1'b1;
        end
        default: begin
          state <= ST_LOAD;
          ready <= 1'b0;
        end
      endcase
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [SW-1:0] s;
    logic [DW-1:0] r;
    logic          dbit;
    logic          fb;
    logic          ins;
    logic [SW-1:0] s_next;

    if (l < SW) begin : g_state_lane
      assign dbit = 1'b0;
    end else begin : g_data_lane
      assign dbit = (cnt == CW'(l - SW));
    end

    always_comb begin
      fb = s[SW-1] ^ dbit;
      if (ctl.fibonacci) begin
        fb = fb ^ (^(taps[SW-1:1] & s[SW-2:0]));
      end
      ins    = ctl.feed_forward ? dbit : fb;
      s_next = {s[SW-2:0], ins};
      if (!ctl.fibonacci && ins) begin
        s_next = s_next ^ taps;
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        s <= (l < SW) ? (SW'(1) << l) : '0;
        r <= '0;
      end else if (step) begin
        s <= s_next;
        r <= DW'({r, fb});
      end
    end

    assign col_state[l] = s;
    assign col_data[l]  = r;
  end

endmodule

[tb/parallel_lfsr_scrambler_tb.sv]
// ----------------------------------------------------------------------------
// parallel_lfsr_scrambler_tb
// Self-checking bench for the word-parallel LFSR scrambler. A short directed
// pass covers the register extremes and each form; random phases follow.
// Every accepted word is run through a bit-serial predictor, and each result
// is compared with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module parallel_lfsr_scrambler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW         = plfsr_pkg::STATE_WIDTH_DEF;
  localparam int DW         = plfsr_pkg::WORD_WIDTH_DEF;
  localparam int DFW        = plfsr_pkg::DATA_FIELD_W;
  localparam int SFW        = plfsr_pkg::STATE_FIELD_W;
  localparam int IDX_W      = plfsr_pkg::CFG_IDX_W;
  localparam int CDW        = plfsr_pkg::CFG_DATA_W;
  localparam int TAPW       = plfsr_pkg::TAP_W;
  localparam int SEEDW      = plfsr_pkg::SEED_W;
  localparam int WATCHDOG   = 2000;  // cycles with no transaction or register write
  localparam int MAX_GAP    = 17;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_WORDS = 66;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [DFW-1:0] data;
    logic           restart;
  } word_item_t;

  typedef struct packed {
    logic [DFW-1:0] data_out;
    logic [SFW-1:0] state_out;
  } word_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Local drivers: the channels see known values from time zero
  logic             drv_valid   = 1'b0;
  logic [DFW-1:0]   drv_data    = '0;
  logic             drv_restart = 1'b0;
  logic             mon_ready   = 1'b0;
  logic             cfg_we      = 1'b0;
  logic [IDX_W-1:0] cfg_index   = plfsr_pkg::REG_TAP_MASK;
  logic [CDW-1:0]   cfg_wdata   = '0;

  plfsr_in_if  in_if ();
  plfsr_out_if out_if ();

  assign in_if.valid   = drv_valid;
  assign in_if.data_in = drv_data;
  assign in_if.restart = drv_restart;
  assign out_if.ready  = mon_ready;

  parallel_lfsr_scrambler DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the register bank and the LFSR state
  logic [TAPW-1:0]  tap_sh   = plfsr_pkg::TAP_RST;
  logic             fib_sh   = 1'b0;
  logic             ff_sh    = 1'b0;
  logic             rev_sh   = 1'b0;
  logic [SEEDW-1:0] seed_sh  = plfsr_pkg::SEED_RST;
  logic [SW-1:0]    lfsr_sh  = SW'(plfsr_pkg::SEED_RST);

  word_item_t   pending_words[$];
  word_result_t expected_words[$];

  // Idling control, set per phase; a burst phase draws no gaps at all
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;
  int in_hold   = 0;
  int out_stall = 0;

  int mismatches     = 0;
  int words_queued   = 0;
  int words_accepted = 0;
  int results_seen   = 0;
  int settings_done  = 0;
  int restarts_seen  = 0;
  int idle_cycles    = 0;

  function automatic logic [SW-1:0] flip_state(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    for (int i = 0; i < SW; i++) r[SW-1-i] = v[i];
    return r;
  endfunction

  function automatic logic [DW-1:0] flip_word(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    for (int i = 0; i < DW; i++) r[DW-1-i] = v[i];
    return r;
  endfunction

  // Bit-serial scrambler: run one word MSB first and advance the shadow state
  function automatic word_result_t scramble_word(input logic [DFW-1:0] data,
                                                 input logic restart);
    word_result_t  r;
    logic [SW-1:0] s;
    logic [SW-1:0] taps;
    logic [DW-1:0] d;
    logic [DW-1:0] res;
    logic          dbit;
    logic          fb;
    logic          ins;
    int            m;
    int            j;
    if (restart) lfsr_sh = seed_sh[SW-1:0];
    s    = lfsr_sh;
    d    = data[DW-1:0];
    taps = tap_sh[SW-1:0] & ~{{(SW-1){1'b0}}, 1'b1};
    res  = '0;
    if (rev_sh) begin
      s = flip_state(s);
      d = flip_word(d);
    end
    for (m = DW - 1; m >= 0; m--) begin
      dbit = d[m];
      fb   = s[SW-1] ^ dbit;
      if (fib_sh) begin
        for (j = 1; j < SW; j++)
          if (taps[j]) fb ^= s[j-1];
      end
      s      = s << 1;
      res[m] = fb;
      ins    = ff_sh ? dbit : fb;
      s[0]   = ins;
      if (!fib_sh && ins) s ^= taps;
    end
    if (rev_sh) begin
      s   = flip_state(s);
      res = flip_word(res);
    end
    lfsr_sh     = s;
    r.data_out  = '0;
    r.data_out[DW-1:0] = res;
    r.state_out = '0;
    r.state_out[SW-1:0] = s;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch on result %0d, %s: got %h, expected %h",
               results_seen, what, got, want);
  endtask

  // Driver: present queued words, predict each one as it is accepted
  always @(posedge clk) begin
    logic       next_valid;
    word_item_t nxt;
    if (rst) begin
      drv_valid <= 1'b0;
      in_hold = 0;
    end else begin
      next_valid = drv_valid;
      if (drv_valid && in_if.ready) begin
        expected_words.push_back(scramble_word(drv_data, drv_restart));
        words_accepted++;
        if (drv_restart) restarts_seen++;
        next_valid = 1'b0;
        in_hold = in_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!next_valid) begin
        if (in_hold > 0) begin
          in_hold--;
        end else if (pending_words.size() > 0) begin
          nxt = pending_words.pop_front();
          drv_data    <= nxt.data;
          drv_restart <= nxt.restart;
          next_valid  = 1'b1;
        end
      end
      // present the next word at once, or drop valid
      drv_valid <= next_valid;
    end
  end

  // Monitor: check each result, then stall for a drawn number of cycles
  always @(posedge clk) begin
    word_result_t want;
    if (rst) begin
      mon_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && mon_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("result with no word pending", out_if.data_out, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_if.data_out !== want.data_out)
            report_mismatch("data_out", out_if.data_out, want.data_out);
          if (out_if.state_out !== want.state_out)
            report_mismatch("state_out", {33'd0, out_if.state_out}, {33'd0, want.state_out});
        end
        results_seen++;
        out_stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      mon_ready <= (out_stall == 0);
    end
  end

  // Watchdog: any transaction or register write counts as progress
  always @(posedge clk) begin
    if (!rst) begin
      if ((drv_valid && in_if.ready) || (out_if.valid && mon_ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles, %0d words and %0d results left",
                 WATCHDOG, pending_words.size(), expected_words.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_word(input logic [DFW-1:0] data, input logic restart);
    word_item_t it;
    it.data    = data;
    it.restart = restart;
    pending_words.push_back(it);
    words_queued++;
  endtask

  // Hold until every queued word has come back as a checked result
  task automatic wait_drained();
    while (results_seen < words_queued)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drive one register write and mirror it; unknown indexes change nothing
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CDW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      plfsr_pkg::REG_TAP_MASK:     tap_sh  = value[TAPW-1:0];
      plfsr_pkg::REG_FIBONACCI:    fib_sh  = value[0];
      plfsr_pkg::REG_FEED_FORWARD: ff_sh   = value[0];
      plfsr_pkg::REG_REVERSE_BITS: rev_sh  = value[0];
      plfsr_pkg::REG_SEED:         seed_sh = value[SEEDW-1:0];
      default: ;
    endcase
  endtask

  // Write all five registers, then drop the write enable. The one-bit
  // registers take full-width values so the upper bits must be dropped.
  task automatic apply_settings(input logic [TAPW-1:0] tap, input logic fib,
                                input logic ff, input logic rev,
                                input logic [SEEDW-1:0] seed);
    logic [CDW-1:0] junk;
    junk = CDW'($urandom);
    write_reg(plfsr_pkg::REG_TAP_MASK, tap);
    write_reg(plfsr_pkg::REG_FIBONACCI, {junk[CDW-1:1], fib});
    write_reg(plfsr_pkg::REG_FEED_FORWARD, {junk[CDW-1:1], ff});
    write_reg(plfsr_pkg::REG_REVERSE_BITS, {junk[CDW-1:1], rev});
    write_reg(plfsr_pkg::REG_SEED, seed);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [TAPW-1:0]  tap;
    logic [SEEDW-1:0] seed;
    logic [IDX_W-1:0] bad_idx;
    int               p;
    int               k;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values first, straight out of reset and the rebuild
    queue_word(64'h0, 1'b1);
    queue_word({64{1'b1}}, 1'b0);
    queue_word(64'h8000_0000_0000_0001, 1'b0);
    wait_drained();

    // Fibonacci, every tap (bit 0 must be ignored), zero seed
    apply_settings({TAPW{1'b1}}, 1'b1, 1'b0, 1'b0, '0);
    queue_word(64'h0, 1'b1);
    queue_word({64{1'b1}}, 1'b0);
    queue_word(64'h0123_4567_89ab_cdef, 1'b0);
    wait_drained();

    // Galois, no taps, descrambler with reversal, full seed
    apply_settings('0, 1'b0, 1'b1, 1'b1, {SEEDW{1'b1}});
    queue_word({$urandom, $urandom}, 1'b1);
    queue_word({$urandom, $urandom}, 1'b0);
    queue_word(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    wait_drained();

    // Top tap only, Fibonacci descrambler, reversed, seed of one
    apply_settings(31'h4000_0000, 1'b1, 1'b1, 1'b1, 31'h1);
    queue_word(64'h5555_5555_5555_5555, 1'b1);
    queue_word(64'h8000_0000_0000_0000, 1'b0);
    queue_word(64'h0000_0000_0000_0001, 1'b0);
    wait_drained();

    // Writes to unknown indexes must not disturb anything; tap on bit 0 only
    for (k = int'(plfsr_pkg::REG_SEED) + 1; k < (1 << IDX_W); k++)
      write_reg(IDX_W'(k), {CDW{1'b1}});
    apply_settings(31'h1, 1'b0, 1'b0, 1'b1, 31'h2aaa_aaaa);
    queue_word({$urandom, $urandom}, 1'b1);
    queue_word({$urandom, $urandom}, 1'b0);
    queue_word({$urandom, $urandom}, 1'b1);
    wait_drained();

    // Random phases
    for (p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       tap = plfsr_pkg::TAP_RST;
        1:       tap = {TAPW{1'b1}};
        2:       tap = '0;
        3:       tap = (31'h1 << $urandom_range(1, SW - 1))
                       | (31'h1 << $urandom_range(1, SW - 1)) | 31'h1;
        default: tap = TAPW'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       seed = '0;
        1:       seed = {SEEDW{1'b1}};
        default: seed = SEEDW'($urandom);
      endcase
      if ($urandom_range(0, 2) == 0) begin
        bad_idx = IDX_W'($urandom_range(int'(plfsr_pkg::REG_SEED) + 1, (1 << IDX_W) - 1));
        write_reg(bad_idx, CDW'($urandom));
      end
      apply_settings(tap, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), seed);
      in_burst  = ($urandom_range(0, 2) == 0);
      out_burst = ($urandom_range(0, 2) == 0);
      for (k = 0; k < PHASE_WORDS; k++) begin
        case ($urandom_range(0, 15))
          0:       queue_word('0, ($urandom_range(0, 11) == 0));
          1:       queue_word({64{1'b1}}, ($urandom_range(0, 11) == 0));
          default: queue_word({$urandom, $urandom},
                              (k == 0) ? 1'($urandom_range(0, 1))
                                       : ($urandom_range(0, 11) == 0));
        endcase
      end
      wait_drained();
    end

    // Let any stray result surface before the verdict
    repeat (8) @(posedge clk);

    $display("covered %0d words (%0d restarts), %0d results checked, %0d register settings",
             words_accepted, restarts_seen, results_seen, settings_done);
    $display("forms: Galois and Fibonacci, scrambler and descrambler, with and without reversal");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/plfsr_pkg.sv
hdl/plfsr_if.sv
hdl/plfsr_matrix.sv
hdl/parallel_lfsr_scrambler.sv
tb/parallel_lfsr_scrambler_tb.sv
